// ===== rtl/core/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the streaming pair-sum matcher.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int EPOCH_W = 8;

  localparam logic [VALUE_W-1:0] HASH_MULT   = 32'h9E37_79B1;
  localparam logic [POS_W-1:0]   POS_DROPPED = 8'hFF;

  typedef enum logic [1:0] {
    ST_PAIR     = 2'd0,
    ST_NO_PAIR  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    hash_start;
    logic    hash_value;
    logic    probe_init;
    logic    probe_next;
    logic    record_hit;
    logic    tbl_write;
    logic    count;
    logic    emit;
    status_e kind;
    logic    end_set;
    logic    clr_step;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic comp_ok;
    logic last;
    logic hash_done;
    logic live;
    logic match;
    logic last_probe;
    logic hit;
    logic pair_seen;
    logic out_free;
    logic epoch_wrap;
    logic clr_last;
  } stat_t;

endpackage

// ===== rtl/core/sps_hash.sv =====
// ----------------------------------------------------------------------------
// sps_hash
// Multiplicative hash with fold, reduced to a table slot. Power-of-two
// tables take a mask; other sizes take a four-bit-per-cycle remainder.
// ----------------------------------------------------------------------------
module sps_hash import sps_pkg::*; #(
  parameter int TABLE_SLOTS = 512
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [VALUE_W-1:0]               key_i,
  output logic                             done_o,
  output logic [$clog2(TABLE_SLOTS)-1:0]   slot_o
);

  localparam int  SLOT_W  = $clog2(TABLE_SLOTS);
  localparam bit  IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam int  DIGIT   = 4;
  localparam int  STEPS   = VALUE_W / DIGIT;
  localparam int  CNT_W   = $clog2(STEPS);

  logic [VALUE_W-1:0] prod_q;
  logic [VALUE_W-1:0] bits_q;
  logic [SLOT_W-1:0]  rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               mul_q;
  logic               div_q;
  logic               done_q;

  logic [VALUE_W-1:0] fold;
  logic [SLOT_W-1:0]  rem_next;

  assign fold = prod_q ^ (prod_q >> 16);

  always_comb begin
    logic [SLOT_W:0] t;
    rem_next = rem_q;
    for (int k = 0; k < DIGIT; k++) begin
      t = {rem_next, bits_q[VALUE_W-1-k]};
      if (t >= (SLOT_W+1)'(TABLE_SLOTS)) begin
        t = t - (SLOT_W+1)'(TABLE_SLOTS);
      end
      rem_next = t[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      mul_q  <= 1'b1;
      div_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (mul_q) begin
      mul_q <= 1'b0;
      cnt_q <= '0;
      if (IS_POW2) begin
        done_q <= 1'b1;
      end else begin
        div_q <= 1'b1;
      end
    end else if (div_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        div_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= key_i * HASH_MULT;
    end else if (mul_q) begin
      if (IS_POW2) begin
        rem_q <= fold[SLOT_W-1:0];
      end else begin
        bits_q <= fold;
        rem_q  <= '0;
      end
    end else if (div_q) begin
      rem_q  <= rem_next;
      bits_q <= bits_q << DIGIT;
    end
  end

  assign done_o = done_q;
  assign slot_o = rem_q;

endmodule

// ===== rtl/core/sps_table.sv =====
// ----------------------------------------------------------------------------
// sps_table
// Single-port slot memory holding epoch tag, value and first position.
// ----------------------------------------------------------------------------
module sps_table import sps_pkg::*; #(
  parameter int TABLE_SLOTS = 512
) (
  input  logic                           clk_i,
  input  logic [$clog2(TABLE_SLOTS)-1:0] addr_i,
  input  logic                           we_i,
  input  entry_t                         wdata_i,
  output entry_t                         rdata_o
);

  entry_t mem [TABLE_SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sps_dp.sv =====
// ----------------------------------------------------------------------------
// sps_dp
// Datapath: target register, complement, hash, probe pointer, slot table,
// per-set counters and the result register.
// ----------------------------------------------------------------------------
module sps_dp import sps_pkg::*; #(
  parameter int MAX_ITEMS   = 256,
  parameter int TABLE_SLOTS = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic                cfg_valid_i,
  input  logic [VALUE_W-1:0]  cfg_target_sum_i,
  input  logic [VALUE_W-1:0]  in_value_i,
  input  logic                in_last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          out_status_o,
  output logic [VALUE_W-1:0]  out_earlier_value_o,
  output logic [VALUE_W-1:0]  out_current_value_o,
  output logic [POS_W-1:0]    out_earlier_index_o,
  output logic [POS_W-1:0]    out_current_index_o
);

  localparam int ITEM_W = $clog2(MAX_ITEMS + 1);
  localparam int SLOT_W = $clog2(TABLE_SLOTS);

  logic [VALUE_W-1:0] target_q;
  logic [VALUE_W-1:0] value_q;
  logic               last_q;
  logic [VALUE_W-1:0] comp_q;
  logic               comp_ok_q;
  logic [POS_W-1:0]   pos_q;
  logic [VALUE_W-1:0] key_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [SLOT_W-1:0]  probe_q;
  logic               hit_q;
  logic [VALUE_W-1:0] hit_value_q;
  logic [POS_W-1:0]   hit_pos_q;
  logic [ITEM_W-1:0]  items_q;
  logic               pair_seen_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic [SLOT_W-1:0]  clr_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [VALUE_W-1:0] out_earlier_value_q;
  logic [VALUE_W-1:0] out_current_value_q;
  logic [POS_W-1:0]   out_earlier_index_q;
  logic [POS_W-1:0]   out_current_index_q;

  logic [VALUE_W:0]   comp_wide;
  logic [VALUE_W-1:0] hash_key;
  logic               hash_done;
  logic [SLOT_W-1:0]  hash_slot;
  logic [SLOT_W-1:0]  slot_next;
  logic               clr_last;
  logic [SLOT_W-1:0]  tbl_addr;
  logic               tbl_we;
  entry_t             tbl_wdata;
  entry_t             tbl_rdata;

  assign comp_wide = {target_q[VALUE_W-1], target_q} - {in_value_i[VALUE_W-1], in_value_i};
  assign hash_key  = cmd_i.hash_value ? value_q : comp_q;
  assign slot_next = (slot_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_q + 1'b1;
  assign clr_last  = clr_q == SLOT_W'(TABLE_SLOTS - 1);

  sps_hash #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.hash_start),
    .key_i   (hash_key),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  assign tbl_addr  = cmd_i.clr_step ? clr_q : slot_q;
  assign tbl_we    = cmd_i.clr_step | cmd_i.tbl_write;
  assign tbl_wdata = cmd_i.clr_step ? entry_t'('0) : entry_t'{epoch_q, value_q, pos_q};

  sps_table #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .addr_i  (tbl_addr),
    .we_i    (tbl_we),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata)
  );

  always_comb begin
    stat_o            = '0;
    stat_o.full       = items_q == ITEM_W'(MAX_ITEMS);
    stat_o.comp_ok    = comp_ok_q;
    stat_o.last       = last_q;
    stat_o.hash_done  = hash_done;
    stat_o.live       = tbl_rdata.tag == epoch_q;
    stat_o.match      = tbl_rdata.value == key_q;
    stat_o.last_probe = probe_q == SLOT_W'(TABLE_SLOTS - 1);
    stat_o.hit        = hit_q;
    stat_o.pair_seen  = pair_seen_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
    stat_o.epoch_wrap = epoch_q == '1;
    stat_o.clr_last   = clr_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      items_q     <= '0;
      pair_seen_q <= 1'b0;
      epoch_q     <= EPOCH_W'(1);
      clr_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        target_q <= cfg_target_sum_i;
      end
      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end else if (cmd_i.record_hit) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.count) begin
        items_q     <= items_q + 1'b1;
        pair_seen_q <= pair_seen_q | hit_q;
      end else if (cmd_i.end_set) begin
        items_q     <= '0;
        pair_seen_q <= 1'b0;
        epoch_q     <= (epoch_q == '1) ? EPOCH_W'(1) : epoch_q + 1'b1;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_last ? '0 : clr_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q   <= in_value_i;
      last_q    <= in_last_i;
      comp_q    <= comp_wide[VALUE_W-1:0];
      comp_ok_q <= comp_wide[VALUE_W] == comp_wide[VALUE_W-1];
      pos_q     <= POS_W'(items_q);
    end
    if (cmd_i.hash_start) begin
      key_q <= hash_key;
    end
    if (cmd_i.probe_init) begin
      slot_q  <= hash_slot;
      probe_q <= '0;
    end else if (cmd_i.probe_next) begin
      slot_q  <= slot_next;
      probe_q <= probe_q + 1'b1;
    end
    if (cmd_i.record_hit) begin
      hit_value_q <= tbl_rdata.value;
      hit_pos_q   <= tbl_rdata.pos;
    end
    if (cmd_i.emit) begin
      out_status_q        <= cmd_i.kind;
      out_current_value_q <= value_q;
      unique case (cmd_i.kind)
        ST_PAIR: begin
          out_earlier_value_q <= hit_value_q;
          out_earlier_index_q <= hit_pos_q;
          out_current_index_q <= pos_q;
        end
        ST_NO_PAIR: begin
          out_earlier_value_q <= '0;
          out_earlier_index_q <= '0;
          out_current_index_q <= pos_q;
        end
        default: begin
          out_earlier_value_q <= '0;
          out_earlier_index_q <= '0;
          out_current_index_q <= POS_DROPPED;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_earlier_value_o = out_earlier_value_q;
  assign out_current_value_o = out_current_value_q;
  assign out_earlier_index_o = out_earlier_index_q;
  assign out_current_index_o = out_current_index_q;

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result written over an untaken beat");

  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.record_hit |-> !hit_q)
    else $error("second hit recorded for one item");

  a_items_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q <= ITEM_W'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("epoch matches cleared tag");

  a_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_step |-> !(cmd_i.tbl_write || cmd_i.load))
    else $error("insert or load during clearing pass");

endmodule

// ===== rtl/core/sps_ctrl.sv =====
// ----------------------------------------------------------------------------
// sps_ctrl
// Sequencer: accept, hash, probe for the complement, probe to insert,
// report, end of set and clearing pass.
// ----------------------------------------------------------------------------
module sps_ctrl import sps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HASH_WAIT,
    S_READ,
    S_CHECK,
    S_FINISH,
    S_EMIT,
    S_END
  } state_e;

  state_e  state_q, state_d;
  logic    find_q, find_d;
  status_e kind_q, kind_d;

  always_comb begin
    state_d    = state_q;
    find_d     = find_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.full) begin
            kind_d  = ST_OVERFLOW;
            state_d = S_EMIT;
          end else begin
            find_d  = 1'b1;
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        cmd_o.hash_start = 1'b1;
        cmd_o.hash_value = !(find_q && stat_i.comp_ok);
        find_d           = find_q && stat_i.comp_ok;
        state_d          = S_HASH_WAIT;
      end
      S_HASH_WAIT: begin
        if (stat_i.hash_done) begin
          cmd_o.probe_init = 1'b1;
          state_d          = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (find_q) begin
          if (!stat_i.live) begin
            find_d  = 1'b0;
            state_d = S_HASH;
          end else if (stat_i.match) begin
            cmd_o.record_hit = 1'b1;
            find_d           = 1'b0;
            state_d          = S_HASH;
          end else if (stat_i.last_probe) begin
            find_d  = 1'b0;
            state_d = S_HASH;
          end else begin
            cmd_o.probe_next = 1'b1;
            state_d          = S_READ;
          end
        end else begin
          if (!stat_i.live) begin
            cmd_o.tbl_write = 1'b1;
            state_d         = S_FINISH;
          end else if (stat_i.match || stat_i.last_probe) begin
            state_d = S_FINISH;
          end else begin
            cmd_o.probe_next = 1'b1;
            state_d          = S_READ;
          end
        end
      end
      S_FINISH: begin
        cmd_o.count = 1'b1;
        if (stat_i.hit) begin
          kind_d  = ST_PAIR;
          state_d = S_EMIT;
        end else if (stat_i.last && !stat_i.pair_seen) begin
          kind_d  = ST_NO_PAIR;
          state_d = S_EMIT;
        end else if (stat_i.last) begin
          state_d = S_END;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = stat_i.last ? S_END : S_IDLE;
        end
      end
      S_END: begin
        cmd_o.end_set = 1'b1;
        state_d       = stat_i.epoch_wrap ? S_CLEAR : S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      find_q  <= 1'b0;
      kind_q  <= ST_PAIR;
    end else begin
      state_q <= state_d;
      find_q  <= find_d;
      kind_q  <= kind_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

// ===== rtl/core/stream_pair_sum_match.sv =====
// ----------------------------------------------------------------------------
// stream_pair_sum_match
// Streaming two-sum matcher over sets of signed 32-bit values.
// Input beats carry a value and a last flag; each value is checked against
// the earlier values of its set for a sum equal to the target register.
// The user must write it over the cfg channel while the block is idle; this
// is not enforced. A hit gives a pair beat; a set that ends with no pair gives
// a no-pair beat; an item past MAX_ITEMS is dropped with an overflow beat.
// One item at a time. An item is hashed twice when its complement is in range,
// else once, and each hash is followed by a probe loop over the single-port
// slot memory with a read state and a check state per probe. A report and a
// set end add a state each. The hash is shorter for a power-of-two
// TABLE_SLOTS, and the hash and the probe loop set the cost of an item.
// After reset, and after every 255th set end, a clearing pass over all
// TABLE_SLOTS slots runs with in_ready_o low; cfg writes are still taken.
// A result waits in the output register while the receiver stalls; the
// next item is taken and worked on meanwhile and holds only at its report.
// ----------------------------------------------------------------------------
module stream_pair_sum_match import sps_pkg::*; #(
  parameter int MAX_ITEMS   = 256,
  parameter int TABLE_SLOTS = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic signed [VALUE_W-1:0]  cfg_target_sum_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [VALUE_W-1:0]  in_value_i,
  input  logic                       in_last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 out_status_o,
  output logic signed [VALUE_W-1:0]  out_earlier_value_o,
  output logic signed [VALUE_W-1:0]  out_current_value_o,
  output logic [POS_W-1:0]           out_earlier_index_o,
  output logic [POS_W-1:0]           out_current_index_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  sps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sps_dp #(
    .MAX_ITEMS   (MAX_ITEMS),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_target_sum_i    (cfg_target_sum_i),
    .in_value_i          (in_value_i),
    .in_last_i           (in_last_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_status_o        (out_status_o),
    .out_earlier_value_o (out_earlier_value_o),
    .out_current_value_o (out_current_value_o),
    .out_earlier_index_o (out_earlier_index_o),
    .out_current_index_o (out_current_index_o)
  );

endmodule
